>>> rtl/configurable_calendar_tick_counter_top_defines.svh
// Assertion macros shared by the calendar counter checker.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef CONFIGURABLE_CALENDAR_TICK_COUNTER_TOP_DEFINES_SVH
`define CONFIGURABLE_CALENDAR_TICK_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCAL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCAL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ccal_pkg.sv
// Shared constants, codes and interface structs of the calendar counter.
// No dependencies; imported by the top level, the divider and the configuration registers.
package ccal_pkg;

    localparam int SUBTICKS_PER_STEP = 16;
    localparam int ACC_W             = 4;
    localparam int MAX_STEPS         = 64;
    localparam int STEP_CNT_W        = $clog2(MAX_STEPS + 1);
    localparam int TOTAL_W           = 11;
    localparam int STEP_W            = 14;

    localparam int DIV_N             = 14;
    localparam int DIV_D             = 8;
    localparam int DIV_CNT_W         = $clog2(DIV_N);

    localparam int HOUR_MINUTES      = 60;
    localparam int MINUTE_MAX        = 59;

    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 8;

    localparam logic [7:0] RST_STEPS_PER_HOUR  = 8'd48;
    localparam logic [5:0] RST_HOURS_PER_DAY   = 6'd18;
    localparam logic [5:0] RST_DAYS_PER_MONTH  = 6'd40;
    localparam logic [5:0] RST_MONTHS_PER_YEAR = 6'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEPS_PER_HOUR  = 2'd0,
        CFG_HOURS_PER_DAY   = 2'd1,
        CFG_DAYS_PER_MONTH  = 2'd2,
        CFG_MONTHS_PER_YEAR = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_ADVANCE = 1'b0,
        OP_LOAD    = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [7:0] sph;
        logic [5:0] hpd;
        logic [5:0] dpm;
        logic [5:0] mpy;
    } cal_cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
        logic [DIV_D-1:0] remainder;
    } div_rsp_t;

endpackage

>>> rtl/configurable_calendar_tick_counter_top.sv
// Calendar counter top level: request handshake, step sequencer, calendar state.
// Load request: busy for one 14-bit divide by 60 on the shared divider.
// Advance request: one divide to find the step within the hour, then one 14-bit
// divide of minute scaling per result step; up to 64 results per request.
// Throughput is set by the one-bit-per-cycle shared divider and by back-pressure on m_ready.
// Synchronous active-low reset clears the calendar and restores the default config.
module configurable_calendar_tick_counter_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ccal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccal_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [9:0]                      s_subtick_count,
    input  logic [5:0]                      s_load_minute,
    input  logic [5:0]                      s_load_hour,
    input  logic [5:0]                      s_load_day,
    input  logic [5:0]                      s_load_month,
    input  logic [15:0]                     s_load_year,
    input  logic [15:0]                     s_load_rel_year,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [5:0]                      m_minute_now,
    output logic [5:0]                      m_hour_now,
    output logic [5:0]                      m_day_now,
    output logic [5:0]                      m_month_now,
    output logic [15:0]                     m_year_now,
    output logic [15:0]                     m_rel_year_now,
    output logic                            m_hour_event,
    output logic                            m_day_event,
    output logic                            m_last_step
);
    import ccal_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LDIV = 6'b000010,
        ST_RDIV = 6'b000100,
        ST_STEP = 6'b001000,
        ST_MDIV = 6'b010000,
        ST_PUSH = 6'b100000
    } state_t;

    cal_cfg_t cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t                state_reg, state_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIV_D-1:0]      rem_reg, rem_next;
    logic [5:0]            minute_reg, minute_next;
    logic [5:0]            hour_reg, hour_next;
    logic [5:0]            day_reg, day_next;
    logic [5:0]            month_reg, month_next;
    logic [15:0]           year_reg, year_next;
    logic [15:0]           rel_year_reg, rel_year_next;
    logic [STEP_CNT_W-1:0] left_reg, left_next;
    logic                  hev_reg, hev_next;
    logic                  dev_reg, dev_next;
    logic                  m_valid_reg, m_valid_next;
    logic [5:0]            out_minute_reg, out_minute_next;
    logic [5:0]            out_hour_reg, out_hour_next;
    logic [5:0]            out_day_reg, out_day_next;
    logic [5:0]            out_month_reg, out_month_next;
    logic [15:0]           out_year_reg, out_year_next;
    logic [15:0]           out_rel_year_reg, out_rel_year_next;
    logic                  out_hev_reg, out_hev_next;
    logic                  out_dev_reg, out_dev_next;
    logic                  out_last_reg, out_last_next;

    logic [TOTAL_W-1:0]    total;
    logic [TOTAL_W-1:0]    steps_raw;
    logic [STEP_CNT_W-1:0] steps_cap;
    logic [ACC_W-1:0]      acc_new;
    logic [5:0]            mi_cl;
    logic [5:0]            hr_lim;
    logic [5:0]            hr_cl;
    logic [STEP_W-1:0]     mul_ld;
    logic [STEP_W-1:0]     ld_step;
    logic [STEP_W-1:0]     step_inc;
    logic [DIV_D-1:0]      rem_plus;
    logic [DIV_D-1:0]      rem_inc;
    logic [STEP_W-1:0]     mul_min;
    logic                  hev;
    logic [5:0]            hour_inc;
    logic [5:0]            day_inc;
    logic [5:0]            month_inc;
    logic                  push_fire;

    ccal_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ccal_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        total     = TOTAL_W'(acc_reg) + TOTAL_W'(s_subtick_count);
        steps_raw = TOTAL_W'(total / SUBTICKS_PER_STEP);
        steps_cap = (steps_raw > TOTAL_W'(MAX_STEPS)) ? STEP_CNT_W'(MAX_STEPS)
                                                      : STEP_CNT_W'(steps_raw);
        acc_new   = ACC_W'(total % SUBTICKS_PER_STEP);

        mi_cl   = (s_load_minute > 6'(MINUTE_MAX)) ? 6'(MINUTE_MAX) : s_load_minute;
        hr_lim  = cfg.hpd - 1'b1;
        hr_cl   = (s_load_hour > hr_lim) ? hr_lim : s_load_hour;
        mul_ld  = STEP_W'(mi_cl) * STEP_W'(cfg.sph);
        ld_step = STEP_W'(hour_reg) * STEP_W'(cfg.sph) + div_rsp.quotient;

        step_inc  = step_reg + 1'b1;
        rem_plus  = rem_reg + 1'b1;
        rem_inc   = ((step_inc == '0) || (rem_plus == cfg.sph)) ? '0 : rem_plus;
        hev       = (rem_inc == '0);
        mul_min   = STEP_W'(rem_inc) * STEP_W'(HOUR_MINUTES);
        hour_inc  = hour_reg + 1'b1;
        day_inc   = day_reg + 1'b1;
        month_inc = month_reg + 1'b1;
    end

    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        step_next     = step_reg;
        rem_next      = rem_reg;
        minute_next   = minute_reg;
        hour_next     = hour_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        rel_year_next = rel_year_reg;
        left_next     = left_reg;
        hev_next      = hev_reg;
        dev_next      = dev_reg;

        div_req.start    = 1'b0;
        div_req.dividend = mul_min;
        div_req.divisor  = cfg.sph;

        push_fire         = 1'b0;
        m_valid_next      = m_valid_reg & ~m_ready;
        out_minute_next   = out_minute_reg;
        out_hour_next     = out_hour_reg;
        out_day_next      = out_day_reg;
        out_month_next    = out_month_reg;
        out_year_next     = out_year_reg;
        out_rel_year_next = out_rel_year_reg;
        out_hev_next      = out_hev_reg;
        out_dev_next      = out_dev_reg;
        out_last_next     = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (opcode_t'(s_opcode) == OP_LOAD) begin
                        minute_next      = mi_cl;
                        hour_next        = hr_cl;
                        day_next         = s_load_day;
                        month_next       = s_load_month;
                        year_next        = s_load_year;
                        rel_year_next    = s_load_rel_year;
                        acc_next         = '0;
                        div_req.start    = 1'b1;
                        div_req.dividend = mul_ld;
                        div_req.divisor  = DIV_D'(HOUR_MINUTES);
                        state_next       = ST_LDIV;
                    end else begin
                        acc_next  = acc_new;
                        left_next = steps_cap;
                        if (steps_cap != '0) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = step_reg;
                            div_req.divisor  = cfg.sph;
                            state_next       = ST_RDIV;
                        end
                    end
                end
            end
            ST_LDIV: begin
                if (div_rsp.done) begin
                    step_next  = ld_step;
                    state_next = ST_IDLE;
                end
            end
            ST_RDIV: begin
                if (div_rsp.done) begin
                    rem_next   = div_rsp.remainder;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                step_next = step_inc;
                rem_next  = rem_inc;
                hev_next  = hev;
                dev_next  = 1'b0;
                if (hev) begin
                    hour_next = hour_inc;
                    if (hour_inc >= cfg.hpd) begin
                        hour_next = '0;
                        step_next = '0;
                        dev_next  = 1'b1;
                        day_next  = day_inc;
                        if (day_inc >= cfg.dpm) begin
                            day_next   = '0;
                            month_next = month_inc;
                            if (month_inc >= cfg.mpy) begin
                                month_next    = '0;
                                year_next     = year_reg + 1'b1;
                                rel_year_next = rel_year_reg + 1'b1;
                            end
                        end
                    end
                end
                div_req.start = 1'b1;
                state_next    = ST_MDIV;
            end
            ST_MDIV: begin
                if (div_rsp.done) begin
                    minute_next = div_rsp.quotient[5:0];
                    state_next  = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    push_fire         = 1'b1;
                    m_valid_next      = 1'b1;
                    out_minute_next   = minute_reg;
                    out_hour_next     = hour_reg;
                    out_day_next      = day_reg;
                    out_month_next    = month_reg;
                    out_year_next     = year_reg;
                    out_rel_year_next = rel_year_reg;
                    out_hev_next      = hev_reg;
                    out_dev_next      = dev_reg;
                    out_last_next     = (left_reg == STEP_CNT_W'(1));
                    left_next         = left_reg - 1'b1;
                    state_next        = (left_reg == STEP_CNT_W'(1)) ? ST_IDLE : ST_STEP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            step_reg     <= '0;
            minute_reg   <= '0;
            hour_reg     <= '0;
            day_reg      <= '0;
            month_reg    <= '0;
            year_reg     <= '0;
            rel_year_reg <= '0;
            left_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            step_reg     <= step_next;
            minute_reg   <= minute_next;
            hour_reg     <= hour_next;
            day_reg      <= day_next;
            month_reg    <= month_next;
            year_reg     <= year_next;
            rel_year_reg <= rel_year_next;
            left_reg     <= left_next;
            m_valid_reg  <= m_valid_next;
        end
        rem_reg          <= rem_next;
        hev_reg          <= hev_next;
        dev_reg          <= dev_next;
        if (push_fire) begin
            out_minute_reg   <= out_minute_next;
            out_hour_reg     <= out_hour_next;
            out_day_reg      <= out_day_next;
            out_month_reg    <= out_month_next;
            out_year_reg     <= out_year_next;
            out_rel_year_reg <= out_rel_year_next;
            out_hev_reg      <= out_hev_next;
            out_dev_reg      <= out_dev_next;
            out_last_reg     <= out_last_next;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_minute_now   = out_minute_reg;
    assign m_hour_now     = out_hour_reg;
    assign m_day_now      = out_day_reg;
    assign m_month_now    = out_month_reg;
    assign m_year_now     = out_year_reg;
    assign m_rel_year_now = out_rel_year_reg;
    assign m_hour_event   = out_hev_reg;
    assign m_day_event    = out_dev_reg;
    assign m_last_step    = out_last_reg;

endmodule

>>> rtl/ccal_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ccal_pkg for widths and the request and response structs.
module ccal_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  ccal_pkg::div_req_t req,
    output ccal_pkg::div_rsp_t rsp
);
    import ccal_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N-1:0]     work_reg, work_next;
    logic [DIV_D-1:0]     rem_reg, rem_next;
    logic [DIV_D-1:0]     dvsr_reg, dvsr_next;
    logic [DIV_D:0]       trial;
    logic [DIV_D:0]       diff;
    logic                 ge;

    always_comb begin
        trial     = {rem_reg, work_reg[DIV_N-1]};
        diff      = trial - {1'b0, dvsr_reg};
        ge        = (trial >= {1'b0, dvsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_N - 1);
            work_next = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
        end else if (busy_reg) begin
            work_next = {work_reg[DIV_N-2:0], ge};
            rem_next  = ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = work_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> rtl/ccal_cfg.sv
// Configuration registers of the calendar counter and their effective values.
// Depends on ccal_pkg for register codes, reset values and the config struct.
module ccal_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ccal_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccal_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output ccal_pkg::cal_cfg_t               cfg
);
    import ccal_pkg::*;

    logic [7:0] sph_reg, sph_next;
    logic [5:0] hpd_reg, hpd_next;
    logic [5:0] dpm_reg, dpm_next;
    logic [5:0] mpy_reg, mpy_next;

    always_comb begin
        sph_next = sph_reg;
        hpd_next = hpd_reg;
        dpm_next = dpm_reg;
        mpy_next = mpy_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_STEPS_PER_HOUR:  sph_next = cfg_wdata;
                CFG_HOURS_PER_DAY:   hpd_next = cfg_wdata[5:0];
                CFG_DAYS_PER_MONTH:  dpm_next = cfg_wdata[5:0];
                CFG_MONTHS_PER_YEAR: mpy_next = cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sph_reg <= RST_STEPS_PER_HOUR;
            hpd_reg <= RST_HOURS_PER_DAY;
            dpm_reg <= RST_DAYS_PER_MONTH;
            mpy_reg <= RST_MONTHS_PER_YEAR;
        end else begin
            sph_reg <= sph_next;
            hpd_reg <= hpd_next;
            dpm_reg <= dpm_next;
            mpy_reg <= mpy_next;
        end
    end

    // A register holding zero behaves as one.
    assign cfg.sph = (sph_reg == '0) ? 8'd1 : sph_reg;
    assign cfg.hpd = (hpd_reg == '0) ? 6'd1 : hpd_reg;
    assign cfg.dpm = (dpm_reg == '0) ? 6'd1 : dpm_reg;
    assign cfg.mpy = (mpy_reg == '0) ? 6'd1 : mpy_reg;

endmodule

>>> rtl/ccal_checker.sv
// Port-level checker for the calendar counter, bound to the top level.
// Depends on the assertion macros in configurable_calendar_tick_counter_top_defines.svh.
`include "configurable_calendar_tick_counter_top_defines.svh"

module ccal_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_opcode,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_minute_now,
    input logic [5:0] m_hour_now,
    input logic       m_hour_event,
    input logic       m_day_event,
    input logic       m_last_step
);

    `CCAL_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_minute_now) && $stable(m_hour_now) && $stable(m_last_step), "Stalled result changed")
    `CCAL_ASSERT_NXT(a_load_busy, s_valid && s_ready && s_opcode, !s_ready, "Ready right after a load request")
    `CCAL_ASSERT_IMP(a_day_is_hour, m_valid && m_day_event, m_hour_event && (m_hour_now == 6'd0), "Day event without hour wrap")
    `CCAL_ASSERT_IMP(a_hour_minute, m_valid && m_hour_event, m_minute_now == 6'd0, "Hour event with nonzero minute")
    `CCAL_ASSERT_IMP(a_minute_range, m_valid, m_minute_now <= 6'd59, "Minute out of range")

endmodule

bind configurable_calendar_tick_counter_top ccal_checker u_ccal_checker (.*);

>>> tb/sv/tb_configurable_calendar_tick_counter_top.sv
// Self-checking testbench for configurable_calendar_tick_counter_top.
// Depends on ccal_pkg and the block's RTL; a scoreboard class predicts every step result.
// Directed requests cover the corner cases, then random phases sweep register settings.
module tb_configurable_calendar_tick_counter_top;
    import ccal_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 40;
    localparam int END_WAIT     = 200;
    localparam int PHASES       = 7;
    localparam int PER_PHASE    = 37;

    typedef struct packed {
        opcode_t     op;
        logic [9:0]  subticks;
        logic [5:0]  minute;
        logic [5:0]  hour;
        logic [5:0]  day;
        logic [5:0]  month;
        logic [15:0] year;
        logic [15:0] rel_year;
    } cal_request_t;

    typedef struct packed {
        logic [5:0]  minute;
        logic [5:0]  hour;
        logic [5:0]  day;
        logic [5:0]  month;
        logic [15:0] year;
        logic [15:0] rel_year;
        logic        hour_ev;
        logic        day_ev;
        logic        last;
    } cal_step_t;

    class calendar_scoreboard;
        logic [7:0]  sph_cfg;
        logic [5:0]  hpd_cfg;
        logic [5:0]  dpm_cfg;
        logic [5:0]  mpy_cfg;
        logic [3:0]  acc_subticks;
        logic [13:0] day_step;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_hour;
        logic [5:0]  cur_day;
        logic [5:0]  cur_month;
        logic [15:0] cur_year;
        logic [15:0] cur_rel_year;
        cal_step_t   expected_steps[$];
        int          mismatches;
        int          requests_seen;
        int          steps_seen;

        function void clear_calendar();
            sph_cfg      = RST_STEPS_PER_HOUR;
            hpd_cfg      = RST_HOURS_PER_DAY;
            dpm_cfg      = RST_DAYS_PER_MONTH;
            mpy_cfg      = RST_MONTHS_PER_YEAR;
            acc_subticks = '0;
            day_step     = '0;
            cur_minute   = '0;
            cur_hour     = '0;
            cur_day      = '0;
            cur_month    = '0;
            cur_year     = '0;
            cur_rel_year = '0;
            expected_steps.delete();
            mismatches    = 0;
            requests_seen = 0;
            steps_seen    = 0;
        endfunction

        function int nonzero(input int v);
            return (v == 0) ? 1 : v;
        endfunction

        function void write_register(input cfg_index_t idx, input logic [7:0] value);
            case (idx)
                CFG_STEPS_PER_HOUR:  sph_cfg = value;
                CFG_HOURS_PER_DAY:   hpd_cfg = value[5:0];
                CFG_DAYS_PER_MONTH:  dpm_cfg = value[5:0];
                CFG_MONTHS_PER_YEAR: mpy_cfg = value[5:0];
                default: ;
            endcase
        endfunction

        function void note_request(input cal_request_t r);
            int sph, hpd, dpm, mpy, mi, hr, total, steps, pos, k;
            cal_step_t e;
            sph = nonzero(sph_cfg);
            hpd = nonzero(hpd_cfg);
            dpm = nonzero(dpm_cfg);
            mpy = nonzero(mpy_cfg);
            requests_seen++;
            if (r.op == OP_LOAD) begin
                mi = (r.minute > MINUTE_MAX) ? MINUTE_MAX : r.minute;
                hr = (r.hour > hpd - 1) ? hpd - 1 : r.hour;
                cur_minute   = 6'(mi);
                cur_hour     = 6'(hr);
                cur_day      = r.day;
                cur_month    = r.month;
                cur_year     = r.year;
                cur_rel_year = r.rel_year;
                day_step     = 14'(hr * sph + (mi * sph) / HOUR_MINUTES);
                acc_subticks = '0;
            end else begin
                total = acc_subticks + r.subticks;
                steps = total / SUBTICKS_PER_STEP;
                acc_subticks = 4'(total % SUBTICKS_PER_STEP);
                if (steps > MAX_STEPS) steps = MAX_STEPS;
                for (k = 0; k < steps; k++) begin
                    e = '0;
                    day_step = day_step + 14'd1;
                    pos = day_step % sph;
                    cur_minute = 6'((pos * HOUR_MINUTES) / sph);
                    if (pos == 0) begin
                        e.hour_ev = 1'b1;
                        cur_hour = cur_hour + 6'd1;
                        if (cur_hour >= hpd) begin
                            cur_hour = '0;
                            day_step = '0;
                            e.day_ev = 1'b1;
                            cur_day = cur_day + 6'd1;
                            if (cur_day >= dpm) begin
                                cur_day = '0;
                                cur_month = cur_month + 6'd1;
                                if (cur_month >= mpy) begin
                                    cur_month = '0;
                                    cur_year = cur_year + 16'd1;
                                    cur_rel_year = cur_rel_year + 16'd1;
                                end
                            end
                        end
                    end
                    e.minute   = cur_minute;
                    e.hour     = cur_hour;
                    e.day      = cur_day;
                    e.month    = cur_month;
                    e.year     = cur_year;
                    e.rel_year = cur_rel_year;
                    e.last     = (k + 1 == steps);
                    expected_steps.push_back(e);
                end
            end
        endfunction

        function void check_result(input cal_step_t got);
            cal_step_t e;
            steps_seen++;
            if (expected_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Error: step result %0d arrived with no result pending.", steps_seen);
                return;
            end
            e = expected_steps.pop_front();
            if (got.minute !== e.minute || got.hour !== e.hour || got.day !== e.day ||
                got.month !== e.month || got.year !== e.year ||
                got.rel_year !== e.rel_year || got.hour_ev !== e.hour_ev ||
                got.day_ev !== e.day_ev || got.last !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Error: step %0d expected min=%0d hr=%0d day=%0d mon=%0d ",
                              "yr=%0d rel=%0d hev=%0b dev=%0b last=%0b, got min=%0d hr=%0d ",
                              "day=%0d mon=%0d yr=%0d rel=%0d hev=%0b dev=%0b last=%0b"},
                             steps_seen, e.minute, e.hour, e.day, e.month, e.year,
                             e.rel_year, e.hour_ev, e.day_ev, e.last, got.minute,
                             got.hour, got.day, got.month, got.year, got.rel_year,
                             got.hour_ev, got.day_ev, got.last);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_opcode;
    logic [9:0]            s_subtick_count;
    logic [5:0]            s_load_minute;
    logic [5:0]            s_load_hour;
    logic [5:0]            s_load_day;
    logic [5:0]            s_load_month;
    logic [15:0]           s_load_year;
    logic [15:0]           s_load_rel_year;
    logic                  m_valid;
    logic                  m_ready;
    logic [5:0]            m_minute_now;
    logic [5:0]            m_hour_now;
    logic [5:0]            m_day_now;
    logic [5:0]            m_month_now;
    logic [15:0]           m_year_now;
    logic [15:0]           m_rel_year_now;
    logic                  m_hour_event;
    logic                  m_day_event;
    logic                  m_last_step;

    calendar_scoreboard sb;
    bit tx_burst;
    bit rx_burst;
    bit long_hold_req;
    int cycle_count;
    int settings_count;

    configurable_calendar_tick_counter_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_subtick_count (s_subtick_count),
        .s_load_minute   (s_load_minute),
        .s_load_hour     (s_load_hour),
        .s_load_day      (s_load_day),
        .s_load_month    (s_load_month),
        .s_load_year     (s_load_year),
        .s_load_rel_year (s_load_rel_year),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_minute_now    (m_minute_now),
        .m_hour_now      (m_hour_now),
        .m_day_now       (m_day_now),
        .m_month_now     (m_month_now),
        .m_year_now      (m_year_now),
        .m_rel_year_now  (m_rel_year_now),
        .m_hour_event    (m_hour_event),
        .m_day_event     (m_day_event),
        .m_last_step     (m_last_step)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic cal_request_t advance_req(input int subticks);
        cal_request_t r;
        r = '0;
        r.op = OP_ADVANCE;
        r.subticks = 10'(subticks);
        return r;
    endfunction

    function automatic cal_request_t load_req(input int mi, input int hr, input int d,
                                              input int mo, input int yr, input int ry);
        cal_request_t r;
        r = '0;
        r.op       = OP_LOAD;
        r.minute   = 6'(mi);
        r.hour     = 6'(hr);
        r.day      = 6'(d);
        r.month    = 6'(mo);
        r.year     = 16'(yr);
        r.rel_year = 16'(ry);
        return r;
    endfunction

    function automatic cal_request_t random_request(input int hpd, input int dpm,
                                                    input int mpy);
        cal_request_t r;
        int pick;
        r.subticks = 10'($urandom_range(0, 1023));
        r.minute   = 6'($urandom_range(0, 63));
        r.hour     = 6'($urandom_range(0, 63));
        r.day      = 6'($urandom_range(0, 63));
        r.month    = 6'($urandom_range(0, 63));
        r.year     = 16'($urandom_range(0, 65535));
        r.rel_year = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            r.op = OP_LOAD;
            if ($urandom_range(0, 99) < 60) r.hour = 6'($urandom_range(0, hpd - 1));
            if ($urandom_range(0, 99) < 75) r.day = 6'($urandom_range(0, dpm - 1));
            if ($urandom_range(0, 99) < 75) r.month = 6'($urandom_range(0, mpy - 1));
        end else begin
            r.op = OP_ADVANCE;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                r.subticks = 10'($urandom_range(0, 160));
            end else if (pick < 90) begin
                r.subticks = 10'($urandom_range(0, 1023));
            end else begin
                case ($urandom_range(0, 3))
                    0: r.subticks = 10'd0;
                    1: r.subticks = 10'd15;
                    2: r.subticks = 10'd16;
                    default: r.subticks = 10'd1023;
                endcase
            end
        end
        return r;
    endfunction

    task automatic send_request(input cal_request_t r);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_opcode        <= r.op;
        s_subtick_count <= r.subticks;
        s_load_minute   <= r.minute;
        s_load_hour     <= r.hour;
        s_load_day      <= r.day;
        s_load_month    <= r.month;
        s_load_year     <= r.year;
        s_load_rel_year <= r.rel_year;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_steps.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        sb.write_register(idx, CFG_DATA_W'(value));
    endtask

    task automatic program_calendar(input int sph, input int hpd, input int dpm,
                                    input int mpy);
        write_register(CFG_STEPS_PER_HOUR, sph);
        write_register(CFG_HOURS_PER_DAY, hpd);
        write_register(CFG_DAYS_PER_MONTH, dpm);
        write_register(CFG_MONTHS_PER_YEAR, mpy);
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : sink
        int gap;
        cal_step_t got;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                gap = LONG_HOLD;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 15);
            end
            repeat (gap) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.minute   = m_minute_now;
            got.hour     = m_hour_now;
            got.day      = m_day_now;
            got.month    = m_month_now;
            got.year     = m_year_now;
            got.rel_year = m_rel_year_now;
            got.hour_ev  = m_hour_event;
            got.day_ev   = m_day_event;
            got.last     = m_last_step;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        int phase, i;
        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_STEPS_PER_HOUR;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_opcode        = OP_ADVANCE;
        s_subtick_count = '0;
        s_load_minute   = '0;
        s_load_hour     = '0;
        s_load_day      = '0;
        s_load_month    = '0;
        s_load_year     = '0;
        s_load_rel_year = '0;
        tx_burst        = 1'b0;
        rx_burst        = 1'b0;
        long_hold_req   = 1'b0;
        settings_count  = 1;
        sb = new();
        sb.clear_calendar();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_request(advance_req(0));
        send_request(advance_req(15));
        send_request(advance_req(1));
        send_request(advance_req(1023));
        send_request(advance_req(1023));
        send_request(load_req(63, 63, 39, 11, 16'hFFFF, 16'hFFFF));
        send_request(advance_req(16));
        send_request(load_req(59, 17, 45, 20, 16'h8000, 16'h7FFF));
        send_request(advance_req(16));
        send_request(load_req(0, 0, 63, 63, 0, 0));
        send_request(advance_req(1023));
        send_request(load_req(0, 0, 0, 0, 0, 0));
        send_request(advance_req(1023));

        wait_idle();
        program_calendar(0, 0, 0, 0);
        send_request(advance_req(48));
        send_request(load_req(30, 5, 63, 63, 16'hFFFE, 1));
        send_request(advance_req(1023));
        send_request(advance_req(7));

        wait_idle();
        program_calendar(255, 63, 63, 63);
        send_request(load_req(59, 62, 62, 62, 16'h1234, 16'hABCD));
        send_request(advance_req(1023));
        send_request(advance_req(1023));
        send_request(load_req(0, 40, 5, 5, 16'h00FF, 16'hFF00));

        wait_idle();
        program_calendar(2, 4, 63, 63);
        send_request(advance_req(64));
        send_request(advance_req(1000));

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0, 2, 5: program_calendar($urandom_range(1, 6), $urandom_range(1, 3),
                                          $urandom_range(1, 3), $urandom_range(1, 3));
                1: program_calendar($urandom_range(0, 255), $urandom_range(0, 63),
                                    $urandom_range(0, 63), $urandom_range(0, 63));
                3: program_calendar(255, 63, 63, 63);
                4: program_calendar(1, 1, 1, 1);
                default: program_calendar(RST_STEPS_PER_HOUR, RST_HOURS_PER_DAY,
                                          RST_DAYS_PER_MONTH, RST_MONTHS_PER_YEAR);
            endcase
            for (i = 0; i < PER_PHASE; i++) begin
                if (i % 10 == 0) begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                if (phase == 2 && i == 5) begin
                    tx_burst = 1'b1;
                    long_hold_req = 1'b1;
                end
                send_request(random_request(sb.nonzero(sb.hpd_cfg), sb.nonzero(sb.dpm_cfg),
                                            sb.nonzero(sb.mpy_cfg)));
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_steps.size() != 0) @(posedge aclk);
        repeat (END_WAIT) @(posedge aclk);
        if (sb.expected_steps.size() != 0) begin
            sb.mismatches++;
            $display("Error: %0d step results never arrived.", sb.expected_steps.size());
        end
        $display("Run covered %0d requests and %0d step results under %0d register settings,",
                 sb.requests_seen, sb.steps_seen, settings_count);
        $display("with %0d mismatches in %0d cycles.", sb.mismatches, cycle_count);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/ccal_pkg.sv
rtl/ccal_div.sv
rtl/ccal_cfg.sv
rtl/configurable_calendar_tick_counter_top.sv
rtl/ccal_checker.sv
tb/sv/tb_configurable_calendar_tick_counter_top.sv
